// ===== rtl/hmac_sha1_engine_assert.svh =====
// Assertion macros for the HMAC-SHA1 engine
`ifndef HMAC_SHA1_ENGINE_ASSERT_SVH
`define HMAC_SHA1_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define HS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define HS_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HS_ASSERT(label, clk, rstn, prop)
`define HS_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== rtl/hs_pkg.sv =====
// Package for the HMAC-SHA1 engine: types, constants, rotate function
package hs_pkg;
    localparam int unsigned FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_KEY_BYTE = 2'd0,
        MODE_KEY_END  = 2'd1,
        MODE_MSG_BYTE = 2'd2,
        MODE_MSG_END  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] data_byte;
    } item_t;

    typedef enum logic [1:0] {
        PH_READY = 2'd0,
        PH_KEY   = 2'd1,
        PH_MSG   = 2'd2
    } phase_t;

    // back-end sequencer states
    typedef enum logic [4:0] {
        ST_FETCH,
        ST_DISPATCH,
        ST_KEYB,
        ST_KEYHASH_INIT,
        ST_KEYHASH_WAIT,
        ST_PAD_LOAD,
        ST_PAD_WAIT,
        ST_ABSORB,
        ST_ABS_WAIT,
        ST_FIN_START,
        ST_FIN_STEP,
        ST_FIN_WAIT,
        ST_FIN_DONE,
        ST_OUT_FEED,
        ST_OUT_WAIT,
        ST_EMIT,
        ST_AFTER
    } state_t;

    // what the current finish is for
    typedef enum logic [1:0] {
        FIN_KEY   = 2'd0,
        FIN_INNER = 2'd1,
        FIN_OUTER = 2'd2
    } fin_t;

    // what to do once the current step ends
    typedef enum logic [1:0] {
        CONT_NONE  = 2'd0,
        CONT_INNER = 2'd1,
        CONT_ABS   = 2'd2,
        CONT_FIN   = 2'd3
    } cont_t;

    typedef struct packed {
        logic start;
        logic busy;
    } core_ctl_t;

    localparam logic [159:0] SHA_IV = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction
endpackage

// ===== rtl/hs_fifo.sv =====
// Short item queue between the front end and the sequencer
module hs_fifo #(
    parameter int unsigned DEPTH = hs_pkg::FIFO_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  hs_pkg::item_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output hs_pkg::item_t rd_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    hs_pkg::item_t       mem_reg [DEPTH];
    logic [AW-1:0]       wp_reg, rp_reg;
    logic [AW:0]         cnt_reg;
    logic                wr_en, rd_en;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wp_reg] <= wr_data;
        end
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en) begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end
endmodule

// ===== rtl/hs_core.sv =====
// SHA-1 compression unit: one round per cycle, message schedule in a 16-word window
module hs_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  hs_pkg::core_ctl_t ctl_in,
    input  logic [511:0]      blk,
    input  logic [159:0]      cv_in,
    output logic [159:0]      cv_out,
    output logic              busy
);
    logic [511:0] w_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]   rnd_reg;
    logic         run_reg;
    logic [31:0]  f, k, t, wt, wn;

    assign busy = run_reg;
    assign wt = w_reg[511 -: 32];
    assign wn = hs_pkg::rotl(w_reg[511-13*32 -: 32] ^ w_reg[511-8*32 -: 32]
                            ^ w_reg[511-2*32 -: 32] ^ w_reg[511 -: 32], 1);
    assign cv_out = {cv_in[159:128] + a_reg, cv_in[127:96] + b_reg,
                     cv_in[95:64] + c_reg, cv_in[63:32] + d_reg, cv_in[31:0] + e_reg};

    always_comb begin
        if (rnd_reg < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg); k = 32'h5A827999;
        end else if (rnd_reg < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg; k = 32'h6ED9EBA1;
        end else if (rnd_reg < 7'd60) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg); k = 32'h8F1BBCDC;
        end else begin
            f = b_reg ^ c_reg ^ d_reg; k = 32'hCA62C1D6;
        end
        t = hs_pkg::rotl(a_reg, 5) + f + e_reg + k + wt;
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.start) begin
            w_reg <= blk;
            {a_reg, b_reg, c_reg, d_reg, e_reg} <= cv_in;
        end else if (run_reg) begin
            w_reg <= {w_reg[479:0], wn};
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= hs_pkg::rotl(b_reg, 30);
            b_reg <= a_reg;
            a_reg <= t;
        end
        if (!aresetn) begin
            run_reg <= 1'b0;
            rnd_reg <= '0;
        end else if (ctl_in.start) begin
            run_reg <= 1'b1;
            rnd_reg <= '0;
        end else if (run_reg) begin
            rnd_reg <= rnd_reg + 7'd1;
            if (rnd_reg == 7'd79) begin
                run_reg <= 1'b0;
            end
        end
    end

    `include "hmac_sha1_engine_assert.svh"
    `HS_ASSERT(a_rnd_range, aclk, aresetn, run_reg |-> rnd_reg < 7'd80)
    `HS_ASSERT(a_no_restart, aclk, aresetn, run_reg |-> !ctl_in.start)
    `HS_ASSERT(a_done, aclk, aresetn, (run_reg && rnd_reg == 7'd79) |=> !run_reg)
endmodule

// ===== rtl/hs_seq.sv =====
// Back end: carries out queued items, drives the SHA-1 unit and emits the digest
module hs_seq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  hs_pkg::item_t q_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_word,
    output logic [2:0]    m_index,
    output logic          m_last
);
    hs_pkg::state_t state_reg, state_next;
    hs_pkg::phase_t phase_reg, phase_next;
    hs_pkg::fin_t   fin_reg, fin_next;
    hs_pkg::cont_t  cont_reg, cont_next;
    hs_pkg::item_t  it_reg, it_next;

    logic [511:0] key_reg, key_next;
    logic [511:0] buf_reg, buf_next;
    logic [159:0] cv_reg, cv_next;
    logic [159:0] inner_reg, inner_next;
    logic [63:0]  cnt_reg, cnt_next;
    logic [63:0]  bits_reg, bits_next;
    logic         kh_reg, kh_next;
    logic [7:0]   ab_reg, ab_next;      // byte being absorbed
    logic [4:0]   oc_reg, oc_next;      // output/feed counter
    logic [2:0]   fc_reg, fc_next;      // length byte counter
    logic [1:0]   fs_reg, fs_next;      // finish sub-phase: 0 idle, 1 pad and zero, 2 len

    logic [511:0]      core_blk;
    logic [159:0]      core_cv;
    logic              core_busy;
    hs_pkg::core_ctl_t ctl;

    logic [5:0] pos;
    assign pos = cnt_reg[5:0];

    hs_core u_core (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(ctl), .blk(core_blk),
        .cv_in(cv_reg), .cv_out(core_cv), .busy(core_busy)
    );

    assign m_word  = cv_reg[159 - 32*oc_reg[2:0] -: 32];
    assign m_index = oc_reg[2:0];
    assign m_last  = (oc_reg[2:0] == 3'd4);

    always_ff @(posedge aclk) begin
        buf_reg   <= buf_next;
        inner_reg <= inner_next;
        it_reg    <= it_next;
        ab_reg    <= ab_next;
        bits_reg  <= bits_next;
        if (!aresetn) begin
            state_reg <= hs_pkg::ST_FETCH;
            phase_reg <= hs_pkg::PH_READY;
            fin_reg   <= hs_pkg::FIN_KEY;
            cont_reg  <= hs_pkg::CONT_NONE;
            cnt_reg   <= '0;
            kh_reg    <= 1'b0;
            oc_reg    <= '0;
            fc_reg    <= '0;
            fs_reg    <= '0;
            key_reg   <= '0;
            cv_reg    <= hs_pkg::SHA_IV;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            fin_reg   <= fin_next;
            cont_reg  <= cont_next;
            cnt_reg   <= cnt_next;
            kh_reg    <= kh_next;
            oc_reg    <= oc_next;
            fc_reg    <= fc_next;
            fs_reg    <= fs_next;
            key_reg   <= key_next;
            cv_reg    <= cv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        fin_next   = fin_reg;
        cont_next  = cont_reg;
        it_next    = it_reg;
        key_next   = key_reg;
        buf_next   = buf_reg;
        cv_next    = cv_reg;
        inner_next = inner_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        kh_next    = kh_reg;
        ab_next    = ab_reg;
        oc_next    = oc_reg;
        fc_next    = fc_reg;
        fs_next    = fs_reg;
        q_ready    = 1'b0;
        m_tvalid   = 1'b0;
        ctl.start  = 1'b0;
        ctl.busy   = core_busy;
        core_blk   = buf_reg;

        unique case (state_reg)
            hs_pkg::ST_FETCH: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    it_next = q_data;
                    state_next = hs_pkg::ST_DISPATCH;
                end
            end
            hs_pkg::ST_DISPATCH: begin
                if (it_reg.mode == hs_pkg::MODE_KEY_BYTE
                    || it_reg.mode == hs_pkg::MODE_KEY_END) begin
                    if (phase_reg != hs_pkg::PH_KEY) begin
                        key_next = '0; cnt_next = '0; kh_next = 1'b0;
                        phase_next = hs_pkg::PH_KEY;
                    end
                    state_next = hs_pkg::ST_KEYB;
                end else if (phase_reg != hs_pkg::PH_MSG) begin
                    // close key (or reuse stored one) then start inner hash
                    state_next = hs_pkg::ST_KEYB;
                end else begin
                    state_next = hs_pkg::ST_KEYB;
                end
            end
            hs_pkg::ST_KEYB: begin
                if (it_reg.mode == hs_pkg::MODE_KEY_BYTE) begin
                    if (kh_reg) begin
                        ab_next = it_reg.data_byte; cont_next = hs_pkg::CONT_NONE;
                        state_next = hs_pkg::ST_ABSORB;
                    end else if (cnt_reg < 64'd64) begin
                        key_next[511 - 8*pos -: 8] = it_reg.data_byte;
                        cnt_next = cnt_reg + 64'd1;
                        state_next = hs_pkg::ST_FETCH;
                    end else begin
                        cv_next = hs_pkg::SHA_IV;
                        state_next = hs_pkg::ST_KEYHASH_INIT;
                    end
                end else if (phase_reg == hs_pkg::PH_KEY) begin
                    if (kh_reg) begin
                        fin_next = hs_pkg::FIN_KEY;
                        state_next = hs_pkg::ST_FIN_START;
                    end else begin
                        state_next = hs_pkg::ST_PAD_LOAD;
                        fin_next = hs_pkg::FIN_INNER;
                    end
                end else if (phase_reg == hs_pkg::PH_READY) begin
                    state_next = hs_pkg::ST_PAD_LOAD;
                    fin_next = hs_pkg::FIN_INNER;
                end else begin
                    state_next = hs_pkg::ST_AFTER;
                end
            end
            hs_pkg::ST_KEYHASH_INIT: begin
                core_blk = key_reg;
                ctl.start = 1'b1;
                state_next = hs_pkg::ST_KEYHASH_WAIT;
            end
            hs_pkg::ST_KEYHASH_WAIT: begin
                core_blk = key_reg;
                if (!core_busy) begin
                    cv_next = core_cv;
                    kh_next = 1'b1;
                    ab_next = it_reg.data_byte;
                    cont_next = hs_pkg::CONT_NONE;
                    state_next = hs_pkg::ST_ABSORB;
                end
            end
            hs_pkg::ST_PAD_LOAD: begin
                // fin_reg picks inner or outer pad
                for (int i = 0; i < 64; i++) begin
                    core_blk[8*i +: 8] = key_reg[8*i +: 8]
                        ^ ((fin_reg == hs_pkg::FIN_OUTER) ? hs_pkg::OPAD : hs_pkg::IPAD);
                end
                cv_next = hs_pkg::SHA_IV;
                buf_next = core_blk;
                state_next = hs_pkg::ST_PAD_WAIT;
            end
            hs_pkg::ST_PAD_WAIT: begin
                // first free cycle starts the pad block, the next free one collects it
                if (!core_busy) begin
                    if (!oc_reg[4]) begin
                        ctl.start = 1'b1;
                        cnt_next = 64'd64;
                        oc_next[4] = 1'b1;
                    end else begin
                        cv_next = core_cv;
                        oc_next = '0;
                        if (fin_reg == hs_pkg::FIN_OUTER) begin
                            state_next = hs_pkg::ST_OUT_FEED;
                        end else begin
                            phase_next = hs_pkg::PH_MSG;
                            state_next = hs_pkg::ST_AFTER;
                        end
                    end
                end
            end
            hs_pkg::ST_AFTER: begin
                if (it_reg.mode == hs_pkg::MODE_MSG_BYTE) begin
                    ab_next = it_reg.data_byte; cont_next = hs_pkg::CONT_NONE;
                    state_next = hs_pkg::ST_ABSORB;
                end else if (it_reg.mode == hs_pkg::MODE_MSG_END) begin
                    fin_next = hs_pkg::FIN_INNER;
                    state_next = hs_pkg::ST_FIN_START;
                end else begin
                    state_next = hs_pkg::ST_FETCH;
                end
            end
            hs_pkg::ST_ABSORB: begin
                if (pos[1:0] == 2'd0) begin
                    buf_next[511 - 8*pos -: 32] = {ab_reg, 24'd0};
                end else begin
                    buf_next[511 - 8*pos -: 8] = ab_reg;
                end
                cnt_next = cnt_reg + 64'd1;
                if (pos == 6'd63) begin
                    state_next = hs_pkg::ST_ABS_WAIT;
                end else begin
                    state_next = (cont_reg == hs_pkg::CONT_NONE) ? hs_pkg::ST_FETCH
                               : (cont_reg == hs_pkg::CONT_FIN) ? hs_pkg::ST_FIN_STEP
                               : hs_pkg::ST_OUT_FEED;
                end
            end
            hs_pkg::ST_ABS_WAIT: begin
                state_next = hs_pkg::ST_ABS_WAIT;
                if (!core_busy && !ctl.busy) begin
                    ctl.start = (oc_reg[4] == 1'b0);
                    oc_next[4] = 1'b1;
                    if (oc_reg[4]) begin
                        cv_next = core_cv;
                        oc_next[4] = 1'b0;
                        state_next = (cont_reg == hs_pkg::CONT_NONE) ? hs_pkg::ST_FETCH
                                   : (cont_reg == hs_pkg::CONT_FIN) ? hs_pkg::ST_FIN_STEP
                                   : hs_pkg::ST_OUT_FEED;
                    end
                end
            end
            hs_pkg::ST_FIN_START: begin
                bits_next = {cnt_reg[60:0], 3'd0};
                ab_next = hs_pkg::PAD_BYTE;
                fs_next = 2'd1;
                fc_next = '0;
                cont_next = hs_pkg::CONT_FIN;
                state_next = hs_pkg::ST_ABSORB;
            end
            hs_pkg::ST_FIN_STEP: begin
                if (fs_reg == 2'd1 && pos != 6'd56) begin
                    ab_next = 8'd0;
                    state_next = hs_pkg::ST_ABSORB;
                end else if (fs_reg == 2'd1 || (fs_reg == 2'd2 && fc_reg != 3'd0)) begin
                    fs_next = 2'd2;
                    ab_next = bits_reg[63 - 8*fc_reg -: 8];
                    fc_next = fc_reg + 3'd1;
                    state_next = hs_pkg::ST_ABSORB;
                end else begin
                    state_next = hs_pkg::ST_FIN_DONE;
                end
            end
            hs_pkg::ST_FIN_DONE: begin
                fs_next = '0;
                unique case (fin_reg)
                    hs_pkg::FIN_KEY: begin
                        key_next = {cv_reg, 352'd0};
                        kh_next = 1'b0;
                        fin_next = hs_pkg::FIN_INNER;
                        state_next = hs_pkg::ST_PAD_LOAD;
                    end
                    hs_pkg::FIN_INNER: begin
                        inner_next = cv_reg;
                        fin_next = hs_pkg::FIN_OUTER;
                        state_next = hs_pkg::ST_PAD_LOAD;
                    end
                    default: begin
                        oc_next = '0;
                        state_next = hs_pkg::ST_EMIT;
                    end
                endcase
            end
            hs_pkg::ST_OUT_FEED: begin
                if (oc_reg[4:0] == 5'd20) begin
                    oc_next = '0;
                    fin_next = hs_pkg::FIN_OUTER;
                    state_next = hs_pkg::ST_FIN_START;
                end else begin
                    ab_next = inner_reg[159 - 8*oc_reg -: 8];
                    oc_next = oc_reg + 5'd1;
                    cont_next = hs_pkg::CONT_ABS;
                    state_next = hs_pkg::ST_ABSORB;
                end
            end
            hs_pkg::ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    oc_next = oc_reg + 5'd1;
                    if (oc_reg[2:0] == 3'd4) begin
                        oc_next = '0;
                        cnt_next = '0;
                        cv_next = cv_reg;
                        phase_next = hs_pkg::PH_READY;
                        state_next = hs_pkg::ST_FETCH;
                    end
                end
            end
            default: state_next = hs_pkg::ST_FETCH;
        endcase
    end

    `include "hmac_sha1_engine_assert.svh"
    `HS_ASSERT(a_emit_idx, aclk, aresetn, m_tvalid |-> m_index <= 3'd4)
    `HS_ASSERT(a_no_fetch_emit, aclk, aresetn, !(q_ready && m_tvalid))
    `HS_ASSERT(a_last_end, aclk, aresetn, (m_tvalid && m_tready && m_last) |=> !m_tvalid)
endmodule

// ===== rtl/hmac_sha1_engine.sv =====
// HMAC-SHA1 engine top level
// Items (mode, byte) enter a four-deep queue and are carried out one at a time by a sequencer
// that drives one SHA-1 round unit at one round a cycle. Each completed 64-byte block is
// compressed by the round unit before the sequencer takes the next item. Closing a key costs
// one pad block, plus the finish when an over-long key was hashed. The message end marker
// finishes the inner hash, runs the outer pad block and the outer hash, after which the five
// digest words leave on the master side, word 0 first.
module hmac_sha1_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last_word
);
    hs_pkg::item_t in_item, q_item;
    logic          q_valid, q_ready;
    logic [31:0]   word;
    logic [2:0]    idx;

    assign in_item.mode      = hs_pkg::mode_t'(s_tuser);
    assign in_item.data_byte = s_tdata;

    hs_fifo #(.DEPTH(hs_pkg::FIFO_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_data(in_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
    );

    hs_seq u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_item),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_word(word), .m_index(idx), .m_last(m_tlast)
    );

    assign m_tdata = {5'd0, idx, word};
endmodule
